/* rtl/core/mbpm_pkg.sv */
// ----------------------------------------------------------------------------
// mbpm_pkg
// Shared constants, codes and control structs of the multicast buffer pool
// manager.
// ----------------------------------------------------------------------------
package mbpm_pkg;

  // pool geometry, both counts are powers of two
  localparam int MAX_DEST = 4;
  localparam int Q_DEPTH  = 4;
  localparam int POOL_MAX = MAX_DEST * Q_DEPTH;

  localparam int OP_W     = 2;
  localparam int HANDLE_W = $clog2(POOL_MAX);
  localparam int DEST_W   = $clog2(MAX_DEST);
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QLVL_W   = $clog2(Q_DEPTH + 1);
  localparam int FLVL_W   = $clog2(POOL_MAX + 1);
  localparam int CNT_W    = 3;
  localparam int REFS_W   = 3;
  localparam int SEQ_W    = 32;
  localparam int STAT_W   = 2;

  localparam logic [CNT_W-1:0] DEST_COUNT_RESET = CNT_W'(MAX_DEST);

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_PUBLISH = 2'd1;
  localparam logic [OP_W-1:0] OP_TAKE    = 2'd2;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD       = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd3;

  typedef struct packed {
    logic              load;
    logic              cfg_write;
    logic              exec;
    logic              pub_step;
    logic              pub_fin;
    logic [DEST_W-1:0] dest_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             handle_bad;
    logic [CNT_W-1:0] dest_count;
  } dp_stat_t;

endpackage

/* rtl/core/mbpm_ctrl.sv */
// ----------------------------------------------------------------------------
// mbpm_ctrl
// Sequencer: accepts a command, runs the publish loop over the active
// destinations and raises the result strobe.
// ----------------------------------------------------------------------------
module mbpm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  output mbpm_pkg::dp_cmd_t  cmd,
  input  mbpm_pkg::dp_stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_PUB  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [mbpm_pkg::DEST_W-1:0] idx;
  logic [mbpm_pkg::DEST_W-1:0] idx_next;
  logic                        done_next;
  logic                        last_dest;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign last_dest = (mbpm_pkg::CNT_W'(idx) == stat.dest_count - mbpm_pkg::CNT_W'(1));

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    done_next     = 1'b0;
    cmd           = '0;
    cmd.cfg_write = cfg_valid && cfg_ready;
    cmd.dest_idx  = idx;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.op == mbpm_pkg::OP_PUBLISH && !stat.handle_bad) begin
          idx_next   = '0;
          state_next = S_PUB;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PUB: begin
        cmd.pub_step = 1'b1;
        if (last_dest) begin
          state_next = S_FIN;
        end else begin
          idx_next = idx + mbpm_pkg::DEST_W'(1);
        end
      end
      S_FIN: begin
        cmd.pub_fin = 1'b1;
        done_next   = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      done  <= done_next;
    end
  end

endmodule

/* rtl/core/mbpm_datapath.sv */
// ----------------------------------------------------------------------------
// mbpm_datapath
// Free list, destination queues, per-handle sequence numbers and reference
// counts, plus the result registers.
// ----------------------------------------------------------------------------
module mbpm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mbpm_pkg::dp_cmd_t             cmd,
  output mbpm_pkg::dp_stat_t            stat,
  input  logic [mbpm_pkg::CNT_W-1:0]    cfg_data,
  input  logic [mbpm_pkg::OP_W-1:0]     op,
  input  logic [mbpm_pkg::HANDLE_W-1:0] handle,
  input  logic [mbpm_pkg::DEST_W-1:0]   dest_id,
  input  logic [mbpm_pkg::SEQ_W-1:0]    seq_in,
  output logic [mbpm_pkg::STAT_W-1:0]   status,
  output logic [mbpm_pkg::HANDLE_W-1:0] handle_out,
  output logic [mbpm_pkg::SEQ_W-1:0]    seq_out,
  output logic [mbpm_pkg::CNT_W-1:0]    accepted
);

  localparam int POOL_MAX = mbpm_pkg::POOL_MAX;
  localparam int MAX_DEST = mbpm_pkg::MAX_DEST;
  localparam int HANDLE_W = mbpm_pkg::HANDLE_W;
  localparam int FLVL_W   = mbpm_pkg::FLVL_W;
  localparam int QLVL_W   = mbpm_pkg::QLVL_W;
  localparam int QPTR_W   = mbpm_pkg::QPTR_W;
  localparam int CNT_W    = mbpm_pkg::CNT_W;
  localparam int REFS_W   = mbpm_pkg::REFS_W;

  logic [CNT_W-1:0]           dest_count;
  logic [HANDLE_W-1:0]        free_ring [POOL_MAX];
  logic [HANDLE_W-1:0]        free_head;
  logic [FLVL_W-1:0]          free_level;
  logic [HANDLE_W-1:0]        dest_ring [POOL_MAX];
  logic [QPTR_W-1:0]          dest_head [MAX_DEST];
  logic [QLVL_W-1:0]          dest_level [MAX_DEST];
  logic [mbpm_pkg::SEQ_W-1:0] buffer_seq [POOL_MAX];
  logic [REFS_W-1:0]          buffer_refs [POOL_MAX];

  // latched command
  logic [mbpm_pkg::OP_W-1:0]   op_q;
  logic [HANDLE_W-1:0]         handle_q;
  logic [mbpm_pkg::DEST_W-1:0] dest_q;
  logic [mbpm_pkg::SEQ_W-1:0]  seq_q;
  logic [CNT_W-1:0]            acc;

  logic [CNT_W-1:0]    refill_count;
  logic [FLVL_W-1:0]   pool_size;
  logic                handle_bad;
  logic                dest_bad;
  logic [HANDLE_W-1:0] alloc_h;
  logic                head_wrap;
  logic [HANDLE_W-1:0] take_h;
  logic [REFS_W-1:0]   refs_cur;
  logic                release_ok;
  logic                pub_room;
  logic [QPTR_W-1:0]   pub_tail;
  logic                push_en;
  logic                push_room;
  logic [FLVL_W-1:0]   push_sum;
  logic [FLVL_W-1:0]   push_idx;

  always_comb begin
    if (rst) begin
      refill_count = mbpm_pkg::DEST_COUNT_RESET;
    end else if (cfg_data == '0) begin
      refill_count = CNT_W'(1);
    end else if (cfg_data > CNT_W'(MAX_DEST)) begin
      refill_count = CNT_W'(MAX_DEST);
    end else begin
      refill_count = cfg_data;
    end
  end

  assign pool_size  = FLVL_W'(dest_count * mbpm_pkg::Q_DEPTH);
  assign handle_bad = (FLVL_W'(handle_q) >= pool_size);
  assign dest_bad   = (CNT_W'(dest_q) >= dest_count);
  assign alloc_h    = free_ring[free_head];
  assign head_wrap  = (FLVL_W'(free_head) == pool_size - FLVL_W'(1));
  assign take_h     = dest_ring[{dest_q, dest_head[dest_q]}];
  assign refs_cur   = buffer_refs[handle_q];
  assign release_ok = !handle_bad && (refs_cur != '0);

  assign pub_room = (dest_level[cmd.dest_idx] < QLVL_W'(mbpm_pkg::Q_DEPTH));
  assign pub_tail = dest_head[cmd.dest_idx] + QPTR_W'(dest_level[cmd.dest_idx]);

  // handle goes back to the free list when its last reference drops or no queue accepts it on publish
  assign push_en   = (cmd.exec && op_q == mbpm_pkg::OP_RELEASE && release_ok &&
                      refs_cur == REFS_W'(1)) ||
                     (cmd.pub_fin && acc == '0);
  assign push_room = (free_level < pool_size);
  assign push_sum  = FLVL_W'(free_head) + free_level;
  assign push_idx  = (push_sum >= pool_size) ? (push_sum - pool_size) : push_sum;

  assign stat.op         = op_q;
  assign stat.handle_bad = handle_bad;
  assign stat.dest_count = dest_count;

  always_ff @(posedge clk) begin
    if (rst || cmd.cfg_write) begin
      dest_count <= refill_count;
      for (int i = 0; i < POOL_MAX; i++) begin
        free_ring[i]   <= HANDLE_W'(i);
        buffer_refs[i] <= '0;
      end
      for (int i = 0; i < MAX_DEST; i++) begin
        dest_head[i]  <= '0;
        dest_level[i] <= '0;
      end
      free_head  <= '0;
      free_level <= FLVL_W'(refill_count * mbpm_pkg::Q_DEPTH);
    end else begin
      if (cmd.exec) begin
        case (op_q)
          mbpm_pkg::OP_ALLOC: begin
            if (free_level != '0) begin
              free_head  <= head_wrap ? '0 : free_head + HANDLE_W'(1);
              free_level <= free_level - FLVL_W'(1);
            end
          end
          mbpm_pkg::OP_TAKE: begin
            if (!dest_bad && dest_level[dest_q] != '0) begin
              dest_head[dest_q]  <= dest_head[dest_q] + QPTR_W'(1);
              dest_level[dest_q] <= dest_level[dest_q] - QLVL_W'(1);
            end
          end
          mbpm_pkg::OP_RELEASE: begin
            if (release_ok) begin
              buffer_refs[handle_q] <= refs_cur - REFS_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.pub_step && pub_room) begin
        dest_level[cmd.dest_idx] <= dest_level[cmd.dest_idx] + QLVL_W'(1);
      end
      if (cmd.pub_fin) begin
        buffer_refs[handle_q] <= REFS_W'(acc);
      end
      if (push_en && push_room) begin
        free_ring[push_idx[HANDLE_W-1:0]] <= handle_q;
        free_level <= free_level + FLVL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= op;
      handle_q <= handle;
      dest_q   <= dest_id;
      seq_q    <= seq_in;
    end
    if (cmd.exec) begin
      status     <= mbpm_pkg::ST_OK;
      handle_out <= '0;
      seq_out    <= '0;
      accepted   <= '0;
      case (op_q)
        mbpm_pkg::OP_ALLOC: begin
          if (free_level == '0) begin
            status <= mbpm_pkg::ST_EMPTY;
          end else begin
            handle_out <= alloc_h;
          end
        end
        mbpm_pkg::OP_PUBLISH: begin
          if (handle_bad) begin
            status <= mbpm_pkg::ST_BAD;
          end else begin
            buffer_seq[handle_q] <= seq_q;
            acc                  <= '0;
          end
        end
        mbpm_pkg::OP_TAKE: begin
          if (dest_bad) begin
            status <= mbpm_pkg::ST_BAD;
          end else if (dest_level[dest_q] == '0) begin
            status <= mbpm_pkg::ST_EMPTY;
          end else begin
            handle_out <= take_h;
            seq_out    <= buffer_seq[take_h];
          end
        end
        mbpm_pkg::OP_RELEASE: begin
          if (handle_bad) begin
            status <= mbpm_pkg::ST_BAD;
          end else if (refs_cur == '0) begin
            status <= mbpm_pkg::ST_UNDERFLOW;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.pub_step && pub_room) begin
      dest_ring[{cmd.dest_idx, pub_tail}] <= handle_q;
      acc <= acc + CNT_W'(1);
    end
    if (cmd.pub_fin) begin
      accepted <= acc;
    end
  end

endmodule

/* rtl/core/multicast_buffer_pool_manager.sv */
// ----------------------------------------------------------------------------
// multicast_buffer_pool_manager
// Reference-counted pool of buffer handles with a free list and one queue
// per active destination.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+----------------------------------------
//  command   | start, busy             | op, handle, dest_id, seq_in
//  result    | done (one-cycle strobe) | status, handle_out, seq_out, accepted
//  config    | cfg_valid, cfg_ready    | cfg_data (dest_count)
//
//  allocate, take and release: done follows the exec state, and the next
//  command is accepted in the done cycle. publish: exec, then one queue per
//  cycle in the destination loop, then the finish state. a config write
//  refills the pool and is taken only while busy is low. synchronous reset
//  restores dest_count 4 and a full free list. results cannot be stalled.
// ----------------------------------------------------------------------------
module multicast_buffer_pool_manager (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mbpm_pkg::OP_W-1:0]     op,
  input  logic [mbpm_pkg::HANDLE_W-1:0] handle,
  input  logic [mbpm_pkg::DEST_W-1:0]   dest_id,
  input  logic [mbpm_pkg::SEQ_W-1:0]    seq_in,
  output logic                          done,
  output logic [mbpm_pkg::STAT_W-1:0]   status,
  output logic [mbpm_pkg::HANDLE_W-1:0] handle_out,
  output logic [mbpm_pkg::SEQ_W-1:0]    seq_out,
  output logic [mbpm_pkg::CNT_W-1:0]    accepted,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbpm_pkg::CNT_W-1:0]    cfg_data
);

  mbpm_pkg::dp_cmd_t  cmd;
  mbpm_pkg::dp_stat_t stat;

  mbpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mbpm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_data   (cfg_data),
    .op         (op),
    .handle     (handle),
    .dest_id    (dest_id),
    .seq_in     (seq_in),
    .status     (status),
    .handle_out (handle_out),
    .seq_out    (seq_out),
    .accepted   (accepted)
  );

endmodule
